// ===== rtl/qss_pkg.sv =====
// ============================================================================
// qss_pkg : shared types and constants of the quaternion slerp smoother
// Payload structs, fixed-point constants and the CORDIC arctangent table.
// ============================================================================
package qss_pkg;

    localparam int RATE_W   = 17;       // Q1.16 rate, 65536 = 1.0
    localparam int COMP_W   = 16;       // Q2.14 quaternion component
    localparam int IDX_W    = 4;
    localparam int DIV_DW   = 64;       // divider dividend / quotient width
    localparam int DIV_SW   = 32;       // divider divisor width
    localparam int SQ_VW    = 64;       // square root operand width
    localparam int SQ_RW    = 32;       // square root result width
    localparam int CORDIC_W = 36;
    localparam int CORDIC_N = 30;

    localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;
    localparam logic signed [COMP_W-1:0] Q14_ONE = 16'sd16384;
    localparam logic signed [32:0] NLERP_DOT = 33'sd268301238;   // 0.9995 in Q.28
    localparam logic signed [CORDIC_W-1:0] CORDIC_KINV = 36'sd652032874;

    typedef struct packed {
        logic [IDX_W-1:0]         tracker_index;
        logic                     tracker_valid;
        logic [RATE_W-1:0]        meas_confidence;
        logic signed [COMP_W-1:0] in_w;
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_w;
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     held;
    } t_out_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] w;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } t_quat;

    localparam t_quat QUAT_IDENT = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};

    // atan(2^-i) in Q.30
    localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

endpackage

// ===== rtl/qss_divu.sv =====
// ============================================================================
// qss_divu : iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse when finished.
// ============================================================================
module qss_divu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [qss_pkg::DIV_DW-1:0] i_dividend,
    input  logic [qss_pkg::DIV_SW-1:0] i_divisor,
    output logic                      o_done,
    output logic [qss_pkg::DIV_DW-1:0] o_quotient
);
    import qss_pkg::*;

    localparam int CNT_W = $clog2(DIV_DW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_SW-1:0] r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_SW-1:0] r_dvs;
    logic [DIV_SW:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIV_DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_SW'(trial - {1'b0, r_dvs}) : DIV_SW'(trial);
            r_quo <= {r_quo[DIV_DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/qss_isqrt.sv =====
// ============================================================================
// qss_isqrt : iterative integer square root
// Floor square root, one result bit per cycle, done pulse when finished.
// ============================================================================
module qss_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [qss_pkg::SQ_VW-1:0] i_value,
    output logic                     o_done,
    output logic [qss_pkg::SQ_RW-1:0] o_root
);
    import qss_pkg::*;

    localparam int CNT_W = $clog2(SQ_RW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_VW-1:0] r_v;
    logic [SQ_VW-1:0] r_r;
    logic [SQ_VW-1:0] r_mask;
    logic [SQ_VW:0]   cand;
    logic             take;

    assign cand = {1'b0, r_r} + {1'b0, r_mask};
    assign take = {1'b0, r_v} >= cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_r    <= '0;
            r_mask <= SQ_VW'(1) << (SQ_VW - 2);
        end else if (r_busy) begin
            if (take) begin
                r_v <= r_v - SQ_VW'(cand);
                r_r <= (r_r >> 1) + r_mask;
            end else begin
                r_r <= r_r >> 1;
            end
            r_mask <= r_mask >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_RW-1:0];

endmodule

// ===== rtl/quaternion_slerp_smoother_unit.sv =====
// ============================================================================
// quaternion_slerp_smoother_unit : per-tracker orientation smoother
// Exponential smoothing of tracker quaternions by nlerp or CORDIC slerp.
// ============================================================================
// Each input transaction carries one tracker's new Q2.14 quaternion. The unit
// blends it into that tracker's stored orientation at rate base_rate times
// the measurement confidence (Q1.16, saturating at 1.0), along the shorter
// arc: nlerp when the dot product is above 0.9995, slerp otherwise, then
// renormalises and writes the result back. One transaction is processed at
// a time and o_in_ready stays low until its result has been placed in the
// output register. A held transaction (invalid, zero rate or index out of
// range) skips the arithmetic. The update time is set by the shared
// bit-serial divider (six quotients on the slerp path) together with the
// bit-serial square root and the 30-step CORDIC, all driven by one
// sequencer around a single 35x35 multiplier. The store resets to
// identity through per-entry valid bits, so no clearing pass is needed.
// Configuration writes take effect at the next transaction.
// ============================================================================
module quaternion_slerp_smoother_unit #(
    parameter int TRACKER_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  qss_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output qss_pkg::t_out_item          o_out,
    input  logic                        i_cfg_we,
    input  logic [qss_pkg::RATE_W-1:0]  i_cfg_data
);
    import qss_pkg::*;

    localparam int IW     = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;
    localparam int MW     = 35;             // multiplier operand width
    localparam int PW     = 2 * MW;
    localparam int R30_W  = 36;             // blended component, Q.30
    localparam int ACC_W  = 50;
    localparam int STEP_W = $clog2(CORDIC_N);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0,  S_RD    = 5'd1,  S_RATE  = 5'd2;
    localparam logic [4:0] S_DOT_M = 5'd3,  S_DOT_A = 5'd4,  S_SIGN  = 5'd5;
    localparam logic [4:0] S_NL_M  = 5'd6,  S_NL_A  = 5'd7,  S_CC_M  = 5'd8;
    localparam logic [4:0] S_CC_A  = 5'd9,  S_SQ1   = 5'd10, S_VEC   = 5'd11;
    localparam logic [4:0] S_TB_M  = 5'd12, S_TB_A  = 5'd13, S_ROT   = 5'd14;
    localparam logic [4:0] S_DIVW  = 5'd15, S_MX_M1 = 5'd16, S_MX_A1 = 5'd17;
    localparam logic [4:0] S_MX_M2 = 5'd18, S_MX_A2 = 5'd19, S_N2_M  = 5'd20;
    localparam logic [4:0] S_N2_A  = 5'd21, S_SQ2   = 5'd22, S_NDIV  = 5'd23;
    localparam logic [4:0] S_NDIVW = 5'd24, S_WR    = 5'd25, S_OUT   = 5'd26;

    // ---------------------------------------------------------------- state
    logic [4:0]               r_state;
    logic [1:0]               r_k;          // quaternion component
    logic                     r_ab;         // 0: weight of stored, 1: of new
    logic [STEP_W-1:0]        r_i;          // CORDIC step

    logic [RATE_W-1:0]        r_base;
    logic [IW-1:0]            r_idx;
    logic                     r_valid;
    logic [RATE_W-1:0]        r_conf;
    logic signed [COMP_W-1:0] r_q [4];
    logic signed [COMP_W-1:0] r_p [4];
    logic signed [COMP_W-1:0] r_res [4];
    logic                     r_held;

    logic [RATE_W-1:0]        r_a;
    logic signed [32:0]       r_d;
    logic [SQ_RW-1:0]         r_s;
    logic signed [CORDIC_W-1:0] r_theta, r_tb;
    logic signed [CORDIC_W-1:0] r_cx, r_cy, r_cz;
    logic                     r_sneg;
    logic signed [MW-1:0]     r_wa, r_wb;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [R30_W-1:0]  r_r30 [4];
    logic [SQ_VW-1:0]         r_n2;
    logic [SQ_RW-1:0]         r_n;

    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [PW-1:0]     r_prod;

    // store: one quaternion per tracker, valid bit set on first write
    t_quat                    r_mem [TRACKER_COUNT];
    logic [TRACKER_COUNT-1:0] r_vld;
    t_quat                    r_rdata;
    logic                     r_rvld;

    t_out_item                r_out;
    logic                     r_ovld;

    // ------------------------------------------------------------- helpers
    logic                     in_acc;
    logic [IW-1:0]            rd_addr;
    logic                     in_range;
    logic [RATE_W-1:0]        base_c;
    logic signed [COMP_W-1:0] p_k, q_k;
    logic signed [R30_W-1:0]  p_ext;
    logic signed [R30_W-1:0]  r28_k, m28_k;
    logic signed [32:0]       d_abs;
    logic signed [CORDIC_W-1:0] c_val;
    logic signed [CORDIC_W-1:0] sh_x, sh_y, at_i, cx_n, cy_n, cz_n, sin_abs;
    logic                     up;
    logic signed [ACC_W-1:0]  mix_sum;
    logic signed [MW-1:0]     w_val;
    logic [DIV_DW-1:0]        q_clamp;
    logic [SQ_VW-1:0]         n2_sum;

    logic                     div_start, div_done;
    logic [DIV_DW-1:0]        div_dvd, div_q;
    logic [DIV_SW-1:0]        div_dvs;
    logic                     sq_start, sq_done;
    logic [SQ_VW-1:0]         sq_val;
    logic [SQ_RW-1:0]         sq_root;

    function automatic logic signed [COMP_W-1:0] sat_q14(logic signed [COMP_W-1:0] v);
        if (v > Q14_ONE)
            return Q14_ONE;
        else if (v < -Q14_ONE)
            return -Q14_ONE;
        else
            return v;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd_addr    = IW'(i_in.tracker_index);
    assign in_range   = int'(i_in.tracker_index) < TRACKER_COUNT;
    assign base_c     = (r_base > RATE_ONE) ? RATE_ONE : r_base;

    assign p_k   = r_p[r_k];
    assign q_k   = r_q[r_k];
    assign p_ext = p_k;
    assign r28_k = r_r30[r_k] >>> 2;
    assign m28_k = (r28_k < 0) ? -r28_k : r28_k;
    assign d_abs = (r_d < 0) ? -r_d : r_d;
    assign c_val = CORDIC_W'(r_d) <<< 2;

    // shared CORDIC step: vectoring drives y to zero, rotation drives z to zero
    assign sh_x = r_cx >>> r_i;
    assign sh_y = r_cy >>> r_i;
    assign at_i = $signed(CORDIC_W'(ATAN_TAB[r_i]));
    assign up   = (r_state == S_VEC) ? (r_cy >= 0) : (r_cz < 0);
    assign cx_n = up ? r_cx + sh_y : r_cx - sh_y;
    assign cy_n = up ? r_cy - sh_x : r_cy + sh_x;
    assign cz_n = up ? r_cz + at_i : r_cz - at_i;
    assign sin_abs = (cy_n < 0) ? -cy_n : cy_n;

    assign mix_sum = r_acc + $signed(r_prod[ACC_W-1:0]);
    assign w_val   = r_sneg ? -$signed(MW'(div_q)) : $signed(MW'(div_q));
    assign q_clamp = (div_q > DIV_DW'(Q14_ONE)) ? DIV_DW'(Q14_ONE) : div_q;
    assign n2_sum  = r_n2 + r_prod[SQ_VW-1:0];

    // ---------------------------------------------------- shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_RD: begin
                mul_a = $signed(MW'(base_c));
                mul_b = $signed(MW'(r_conf));
            end
            S_DOT_M: begin
                mul_a = MW'(p_k);
                mul_b = MW'(q_k);
            end
            S_NL_M: begin
                mul_a = $signed(MW'(r_a));
                mul_b = MW'(q_k) - MW'(p_k);
            end
            S_CC_M: begin
                mul_a = MW'(c_val);
                mul_b = MW'(c_val);
            end
            S_TB_M: begin
                mul_a = $signed(MW'(r_a));
                mul_b = MW'(r_theta);
            end
            S_MX_M1: begin
                mul_a = r_wa;
                mul_b = MW'(p_k);
            end
            S_MX_M2: begin
                mul_a = r_wb;
                mul_b = MW'(q_k);
            end
            S_N2_M: begin
                mul_a = MW'(m28_k);
                mul_b = MW'(m28_k);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ------------------------------------------- divider and root launches
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        sq_start  = 1'b0;
        sq_val    = '0;
        case (r_state)
            S_ROT: begin
                // sin * 2^30 / sin(theta), on magnitudes
                div_start = (r_i == STEP_W'(CORDIC_N - 1));
                div_dvd   = DIV_DW'($unsigned(sin_abs)) << 30;
                div_dvs   = DIV_SW'(r_s);
            end
            S_NDIV: begin
                // rounded |r28| * 2^14 / norm
                div_start = 1'b1;
                div_dvd   = (DIV_DW'($unsigned(m28_k)) << 14) + DIV_DW'(r_n >> 1);
                div_dvs   = DIV_SW'(r_n);
            end
            S_CC_A: begin
                sq_start = 1'b1;
                sq_val   = (SQ_VW'(1) << 60) - r_prod[SQ_VW-1:0];
            end
            S_N2_A: begin
                sq_start = (r_k == 2'd3);
                sq_val   = n2_sum;
            end
            default: begin
                div_start = 1'b0;
                sq_start  = 1'b0;
            end
        endcase
    end

    qss_divu u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    qss_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ----------------------------------------------------------- the store
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (r_state == S_WR)
            r_mem[r_idx] <= '{w: r_res[0], x: r_res[1], y: r_res[2], z: r_res[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[rd_addr];
            if (r_state == S_WR)
                r_vld[r_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= RATE_RESET;
            r_ovld  <= 1'b0;
            r_k     <= '0;
            r_ab    <= 1'b0;
            r_i     <= '0;
        end else begin
            if (i_cfg_we)
                r_base <= i_cfg_data;
            // output register: load from S_OUT, clear once taken
            if (r_state == S_OUT && (!r_ovld || i_out_ready))
                r_ovld <= 1'b1;
            else if (r_ovld && i_out_ready)
                r_ovld <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc)
                        r_state <= in_range ? S_RD : S_OUT;
                end
                S_RD:   r_state <= S_RATE;
                S_RATE: begin
                    r_k <= '0;
                    if (!r_valid || r_prod[32:16] == '0)
                        r_state <= S_OUT;
                    else
                        r_state <= S_DOT_M;
                end
                S_DOT_M: r_state <= S_DOT_A;
                S_DOT_A: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_SIGN : S_DOT_M;
                end
                S_SIGN: begin
                    r_k     <= '0;
                    r_state <= (d_abs > NLERP_DOT) ? S_NL_M : S_CC_M;
                end
                S_NL_M: r_state <= S_NL_A;
                S_NL_A: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_N2_M : S_NL_M;
                end
                S_CC_M: r_state <= S_CC_A;
                S_CC_A: r_state <= S_SQ1;
                S_SQ1: begin
                    if (sq_done) begin
                        r_i     <= '0;
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == STEP_W'(CORDIC_N - 1))
                        r_state <= S_TB_M;
                end
                S_TB_M: r_state <= S_TB_A;
                S_TB_A: begin
                    r_i     <= '0;
                    r_ab    <= 1'b0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == STEP_W'(CORDIC_N - 1))
                        r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_i <= '0;
                        r_k <= '0;
                        if (!r_ab) begin
                            r_ab    <= 1'b1;
                            r_state <= S_ROT;
                        end else begin
                            r_state <= S_MX_M1;
                        end
                    end
                end
                S_MX_M1: r_state <= S_MX_A1;
                S_MX_A1: r_state <= S_MX_M2;
                S_MX_M2: r_state <= S_MX_A2;
                S_MX_A2: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_N2_M : S_MX_M1;
                end
                S_N2_M: r_state <= S_N2_A;
                S_N2_A: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == 2'd3) ? S_SQ2 : S_N2_M;
                end
                S_SQ2: begin
                    if (sq_done) begin
                        r_k     <= '0;
                        r_state <= (sq_root == '0) ? S_WR : S_NDIV;
                    end
                end
                S_NDIV: r_state <= S_NDIVW;
                S_NDIVW: begin
                    if (div_done) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k == 2'd3) ? S_WR : S_NDIV;
                    end
                end
                S_WR: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovld || i_out_ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------ datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_idx   <= rd_addr;
                    r_valid <= i_in.tracker_valid;
                    r_conf  <= (i_in.meas_confidence > RATE_ONE) ? RATE_ONE
                                                                 : i_in.meas_confidence;
                    r_q[0]  <= sat_q14(i_in.in_w);
                    r_q[1]  <= sat_q14(i_in.in_x);
                    r_q[2]  <= sat_q14(i_in.in_y);
                    r_q[3]  <= sat_q14(i_in.in_z);
                    // index beyond the store: identity, nothing written
                    r_res[0] <= QUAT_IDENT.w;
                    r_res[1] <= QUAT_IDENT.x;
                    r_res[2] <= QUAT_IDENT.y;
                    r_res[3] <= QUAT_IDENT.z;
                    r_held   <= 1'b1;
                end
            end
            S_RD: begin
                if (r_rvld) begin
                    r_p[0] <= r_rdata.w;
                    r_p[1] <= r_rdata.x;
                    r_p[2] <= r_rdata.y;
                    r_p[3] <= r_rdata.z;
                end else begin
                    r_p[0] <= QUAT_IDENT.w;
                    r_p[1] <= QUAT_IDENT.x;
                    r_p[2] <= QUAT_IDENT.y;
                    r_p[3] <= QUAT_IDENT.z;
                end
            end
            S_RATE: begin
                r_a <= r_prod[32:16];
                r_d <= '0;
                // hold path returns the stored entry
                r_res[0] <= r_p[0];
                r_res[1] <= r_p[1];
                r_res[2] <= r_p[2];
                r_res[3] <= r_p[3];
            end
            S_DOT_A: r_d <= r_d + $signed(r_prod[32:0]);
            S_SIGN: begin
                // shorter arc
                if (r_d < 0) begin
                    r_d    <= -r_d;
                    r_q[0] <= -r_q[0];
                    r_q[1] <= -r_q[1];
                    r_q[2] <= -r_q[2];
                    r_q[3] <= -r_q[3];
                end
            end
            S_NL_A: begin
                r_r30[r_k] <= (p_ext <<< 16) + $signed(r_prod[R30_W-1:0]);
                r_n2       <= '0;
            end
            S_SQ1: begin
                if (sq_done) begin
                    r_s  <= (sq_root == '0) ? SQ_RW'(1) : sq_root;
                    r_cx <= c_val;
                    r_cy <= $signed(CORDIC_W'(sq_root));
                    r_cz <= '0;
                end
            end
            S_VEC: begin
                r_cx <= cx_n;
                r_cy <= cy_n;
                r_cz <= cz_n;
                if (r_i == STEP_W'(CORDIC_N - 1))
                    r_theta <= cz_n;
            end
            S_TB_A: begin
                r_tb <= CORDIC_W'(r_prod >>> 16);
                r_cx <= CORDIC_KINV;
                r_cy <= '0;
                r_cz <= r_theta - CORDIC_W'(r_prod >>> 16);
            end
            S_ROT: begin
                r_cx <= cx_n;
                r_cy <= cy_n;
                r_cz <= cz_n;
                if (r_i == STEP_W'(CORDIC_N - 1))
                    r_sneg <= cy_n < 0;
            end
            S_DIVW: begin
                if (div_done) begin
                    if (!r_ab) begin
                        r_wa <= w_val;
                        r_cx <= CORDIC_KINV;
                        r_cy <= '0;
                        r_cz <= r_tb;
                    end else begin
                        r_wb <= w_val;
                    end
                end
            end
            S_MX_A1: r_acc <= $signed(r_prod[ACC_W-1:0]);
            S_MX_A2: begin
                r_r30[r_k] <= R30_W'(mix_sum >>> 14);
                r_n2       <= '0;
            end
            S_N2_A: r_n2 <= n2_sum;
            S_SQ2: begin
                if (sq_done) begin
                    r_n    <= sq_root;
                    r_held <= 1'b0;
                    // zero norm falls back to identity
                    r_res[0] <= QUAT_IDENT.w;
                    r_res[1] <= QUAT_IDENT.x;
                    r_res[2] <= QUAT_IDENT.y;
                    r_res[3] <= QUAT_IDENT.z;
                end
            end
            S_NDIVW: begin
                if (div_done)
                    r_res[r_k] <= (r28_k < 0) ? -$signed(COMP_W'(q_clamp))
                                              : $signed(COMP_W'(q_clamp));
            end
            S_OUT: begin
                if (!r_ovld || i_out_ready) begin
                    r_out.out_w <= r_res[0];
                    r_out.out_x <= r_res[1];
                    r_out.out_y <= r_res[2];
                    r_out.out_z <= r_res[3];
                    r_out.held  <= r_held;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

endmodule
